### rtl/srrw_pkg.sv
// ----------------------------------------------------------------------------
// Selective-repeat receive window package
// Shared opcodes, codes and types for the receive window unit.
// ----------------------------------------------------------------------------
`default_nettype none

package srrw_pkg;

    localparam int ID_BITS    = 16;
    localparam int CFG_BITS   = 16;
    localparam int WORD_BITS  = 64;

    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_ARRIVE = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_ARRIVE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_TOTAL   = 1'b1;

    localparam logic KIND_DELIVERY = 1'b0;
    localparam logic KIND_REQUEST  = 1'b1;

    localparam logic [CFG_BITS-1:0] TIMEOUT_RESET = 16'd550;
    localparam logic [CFG_BITS-1:0] TOTAL_RESET   = 16'd1000;

    typedef struct packed {
        logic [1:0]           op;
        logic [ID_BITS-1:0]   id;
        logic [WORD_BITS-1:0] payload;
    } op_entry_t;

    typedef struct packed {
        logic                 kind;
        logic [ID_BITS-1:0]   id;
        logic [WORD_BITS-1:0] payload;
        logic                 done;
        logic                 last;
    } result_t;

    typedef struct packed {
        logic      push;
        op_entry_t entry;
    } push_t;

endpackage

`default_nettype wire

### rtl/srrw_front.sv
// ----------------------------------------------------------------------------
// Receive window front end
// Accepts input requests and turns each start, arrival or tick command into a queued operation.
// ----------------------------------------------------------------------------
`default_nettype none

module srrw_front (
    input  wire logic                        item_valid,
    output logic                             item_stall,
    input  wire logic [1:0]                  command,
    input  wire logic [srrw_pkg::ID_BITS-1:0]   message_id,
    input  wire logic [srrw_pkg::WORD_BITS-1:0] payload,
    input  wire logic                        queue_full,
    output srrw_pkg::push_t                  push
);

    always_comb
    begin
        item_stall          = queue_full;
        push.push           = 1'b0;
        push.entry.op       = srrw_pkg::OP_START;
        push.entry.id       = message_id;
        push.entry.payload  = payload;
        unique case (command)
            srrw_pkg::CMD_START:
            begin
                push.push     = item_valid && !queue_full;
                push.entry.op = srrw_pkg::OP_START;
            end
            srrw_pkg::CMD_ARRIVE:
            begin
                push.push     = item_valid && !queue_full;
                push.entry.op = srrw_pkg::OP_ARRIVE;
            end
            srrw_pkg::CMD_TICK:
            begin
                push.push     = item_valid && !queue_full;
                push.entry.op = srrw_pkg::OP_TICK;
            end
            default:
            begin
                push.push = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/srrw_queue.sv
// ----------------------------------------------------------------------------
// Receive window operation queue
// Two-entry queue that decouples the front end from the window engine.
// ----------------------------------------------------------------------------
`default_nettype none

module srrw_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire srrw_pkg::push_t push,
    input  wire logic          pop,
    output logic               full,
    output logic               head_valid,
    output srrw_pkg::op_entry_t head
);

    srrw_pkg::op_entry_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        full        = (count_reg == 2'd2);
        head_valid  = (count_reg != 2'd0);
        head        = mem_reg[rd_ptr_reg];
        wr_ptr_next = push.push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push.push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### rtl/srrw_back.sv
// ----------------------------------------------------------------------------
// Receive window engine
// Holds the reorder window and the transfer state, executes queued operations
// and emits requests and in-order deliveries one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module srrw_back #(
    parameter int WINDOW       = 16,
    parameter int PAYLOAD_BITS = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [srrw_pkg::CFG_BITS-1:0] cfg_data,
    input  wire logic                          head_valid,
    input  wire srrw_pkg::op_entry_t           head,
    output logic                               pop,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output srrw_pkg::result_t                  result
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int IDB    = srrw_pkg::ID_BITS;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_REQS    = 2'd1;
    localparam logic [1:0] ST_DRAIN_D = 2'd2;
    localparam logic [1:0] ST_DRAIN_R = 2'd3;

    logic [PAYLOAD_BITS-1:0] slot_mem [WINDOW];
    logic [PAYLOAD_BITS-1:0] rd_word_reg;

    logic [1:0]                  state_reg, state_next;
    logic [WINDOW-1:0]           valid_reg, valid_next;
    logic [IDB-1:0]              ne_reg, ne_next;
    logic [SLOT_W-1:0]           ne_slot_reg, ne_slot_next;
    logic [IDB-1:0]              idle_reg, idle_next;
    logic                        fin_reg, fin_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [CNT_W-1:0]            limit_reg, limit_next;
    logic                        more_reg, more_next;
    logic [srrw_pkg::CFG_BITS-1:0] timeout_reg, timeout_next;
    logic [srrw_pkg::CFG_BITS-1:0] total_reg, total_next;
    logic                        out_valid_reg, out_valid_next;
    srrw_pkg::result_t           out_reg, out_next;

    logic                        step;
    logic                        fin_now;
    logic                        in_win;
    logic [IDB-1:0]              offset;
    logic [SLOT_W:0]             slot_sum;
    logic [SLOT_W-1:0]           wslot;
    logic                        mem_we;
    logic [CNT_W-1:0]            start_limit;
    logic [IDB-1:0]              ne_inc;
    logic [SLOT_W-1:0]           slot_inc;
    logic                        fin_inc;
    logic                        more_inc;
    logic                        req_inc;
    logic [IDB:0]                entering;
    logic                        req_last;

    always_comb
    begin
        step     = !out_valid_reg || !result_stall;
        fin_now  = fin_reg || (ne_reg >= total_reg);
        in_win   = (head.id >= ne_reg)
                   && ({1'b0, head.id} < ({1'b0, ne_reg} + (IDB + 1)'(WINDOW)))
                   && (head.id < total_reg);
        offset   = head.id - ne_reg;
        slot_sum = {1'b0, ne_slot_reg} + {1'b0, offset[SLOT_W-1:0]};
        if (slot_sum >= (SLOT_W + 1)'(WINDOW))
        begin
            wslot = SLOT_W'(slot_sum - (SLOT_W + 1)'(WINDOW));
        end
        else
        begin
            wslot = slot_sum[SLOT_W-1:0];
        end
        if (total_reg < srrw_pkg::CFG_BITS'(WINDOW))
        begin
            start_limit = total_reg[CNT_W-1:0];
        end
        else
        begin
            start_limit = CNT_W'(WINDOW);
        end
        ne_inc   = ne_reg + 1'b1;
        slot_inc = (ne_slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : ne_slot_reg + 1'b1;
        fin_inc  = (ne_inc >= total_reg);
        more_inc = !fin_inc && valid_reg[slot_inc];
        req_inc  = ({1'b0, ne_inc} + (IDB + 1)'(WINDOW - 1)) < {1'b0, total_reg};
        entering = {1'b0, ne_reg} + (IDB + 1)'(WINDOW - 1);
        req_last = (cnt_reg == limit_reg - 1'b1);
    end

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        ne_next        = ne_reg;
        ne_slot_next   = ne_slot_reg;
        idle_next      = idle_reg;
        fin_next       = fin_reg;
        cnt_next       = cnt_reg;
        limit_next     = limit_reg;
        more_next      = more_reg;
        timeout_next   = timeout_reg;
        total_next     = total_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        pop            = 1'b0;
        mem_we         = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                srrw_pkg::REG_TIMEOUT: timeout_next = cfg_data;
                srrw_pkg::REG_TOTAL:   total_next   = cfg_data;
                default:               ;
            endcase
        end

        if (step)
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (head_valid)
                    begin
                        pop = 1'b1;
                        unique case (head.op)
                            srrw_pkg::OP_START:
                            begin
                                valid_next   = '0;
                                ne_next      = '0;
                                ne_slot_next = '0;
                                idle_next    = '0;
                                fin_next     = (total_reg == '0);
                                cnt_next     = '0;
                                limit_next   = start_limit;
                                state_next   = (start_limit == '0) ? ST_IDLE : ST_REQS;
                            end
                            srrw_pkg::OP_ARRIVE:
                            begin
                                fin_next = fin_now;
                                if (!fin_now && in_win)
                                begin
                                    mem_we            = 1'b1;
                                    valid_next[wslot] = 1'b1;
                                    if (valid_reg[ne_slot_reg] || (wslot == ne_slot_reg))
                                    begin
                                        state_next = ST_DRAIN_D;
                                    end
                                end
                            end
                            srrw_pkg::OP_TICK:
                            begin
                                fin_next = fin_now;
                                if (!fin_now)
                                begin
                                    if (idle_reg >= timeout_reg)
                                    begin
                                        idle_next        = '0;
                                        out_valid_next   = 1'b1;
                                        out_next.kind    = srrw_pkg::KIND_REQUEST;
                                        out_next.id      = ne_reg;
                                        out_next.payload = '0;
                                        out_next.done    = 1'b0;
                                        out_next.last    = 1'b1;
                                    end
                                    else
                                    begin
                                        idle_next = idle_reg + 1'b1;
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_REQS:
                begin
                    out_valid_next   = 1'b1;
                    out_next.kind    = srrw_pkg::KIND_REQUEST;
                    out_next.id      = IDB'(cnt_reg);
                    out_next.payload = '0;
                    out_next.done    = fin_reg;
                    out_next.last    = req_last;
                    cnt_next         = cnt_reg + 1'b1;
                    if (req_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_DRAIN_D:
                begin
                    out_valid_next          = 1'b1;
                    out_next.kind           = srrw_pkg::KIND_DELIVERY;
                    out_next.id             = ne_reg;
                    out_next.payload        = srrw_pkg::WORD_BITS'(rd_word_reg);
                    out_next.done           = fin_inc;
                    out_next.last           = !req_inc && !more_inc;
                    valid_next[ne_slot_reg] = 1'b0;
                    idle_next               = '0;
                    ne_next                 = ne_inc;
                    ne_slot_next            = slot_inc;
                    fin_next                = fin_inc;
                    more_next               = more_inc;
                    if (req_inc)
                    begin
                        state_next = ST_DRAIN_R;
                    end
                    else if (more_inc)
                    begin
                        state_next = ST_DRAIN_D;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_DRAIN_R:
                begin
                    out_valid_next   = 1'b1;
                    out_next.kind    = srrw_pkg::KIND_REQUEST;
                    out_next.id      = entering[IDB-1:0];
                    out_next.payload = '0;
                    out_next.done    = fin_reg;
                    out_next.last    = !more_reg;
                    state_next       = more_reg ? ST_DRAIN_D : ST_IDLE;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    // The read port follows the next expected slot, so its word is ready when
    // that slot is delivered; a word written to that slot bypasses the array.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[wslot] <= head.payload[PAYLOAD_BITS-1:0];
        end
        if (mem_we && (wslot == ne_slot_next))
        begin
            rd_word_reg <= head.payload[PAYLOAD_BITS-1:0];
        end
        else
        begin
            rd_word_reg <= slot_mem[ne_slot_next];
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        limit_reg <= limit_next;
        more_reg  <= more_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            ne_reg        <= '0;
            ne_slot_reg   <= '0;
            idle_reg      <= '0;
            fin_reg       <= 1'b0;
            cnt_reg       <= '0;
            timeout_reg   <= srrw_pkg::TIMEOUT_RESET;
            total_reg     <= srrw_pkg::TOTAL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            ne_reg        <= ne_next;
            ne_slot_reg   <= ne_slot_next;
            idle_reg      <= idle_next;
            fin_reg       <= fin_next;
            cnt_reg       <= cnt_next;
            timeout_reg   <= timeout_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

### rtl/selective_repeat_receive_window_unit.sv
// ----------------------------------------------------------------------------
// Selective-repeat receive window unit
// Reorders arriving messages in a window of WINDOW slots, delivers them in
// order and issues requests for missing or newly admitted message ids.
// ----------------------------------------------------------------------------
// Input requests carry a command (start, message arrival, millisecond tick)
// with message_id and payload. The front end decodes each accepted start,
// arrival or tick request into a two-entry queue, so requests keep being
// accepted while the engine works or a result waits, until the queue is full.
// The engine takes one operation from the queue per cycle when idle and not
// stalled. A start issues one request per id, up to WINDOW of them, and an
// arrival that completes a run of k messages delivers them in order, each
// followed by a request for a newly admitted id while one remains.
// A tick's re-request is registered in the output register as the tick leaves
// the queue; a start or an arrival first moves the engine into its request or
// drain state, which then registers the first result.
// Results leave through one output register; when the receiver stalls, the
// result holds and the engine waits, and the queue fills behind it.
// Configuration writes are taken at any edge with cfg_we high and should be
// made while the unit is idle. Reset clears the window valid bits, counters
// and queue and loads the register defaults; requests are accepted from the
// first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module selective_repeat_receive_window_unit #(
    parameter int WINDOW       = 16,
    parameter int PAYLOAD_BITS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [1:0]  command,
    input  wire logic [15:0] message_id,
    input  wire logic [63:0] payload,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             kind,
    output logic [15:0]      out_id,
    output logic [63:0]      out_payload,
    output logic             transfer_done,
    output logic             last
);

    srrw_pkg::push_t     push;
    srrw_pkg::op_entry_t head;
    srrw_pkg::result_t   result;
    logic                queue_full;
    logic                head_valid;
    logic                pop;

    srrw_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .command    (command),
        .message_id (message_id),
        .payload    (payload),
        .queue_full (queue_full),
        .push       (push)
    );

    srrw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head)
    );

    srrw_back #(
        .WINDOW       (WINDOW),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assign kind          = result.kind;
    assign out_id        = result.id;
    assign out_payload   = result.payload;
    assign transfer_done = result.done;
    assign last          = result.last;

endmodule

`default_nettype wire
